[hdl/shared_exclusive_lock_queue_defines.svh]
// Assertion macros shared by the lock queue RTL.
// Both expect a signal named clk in the calling scope; SELQ_ASSERT also expects rst_n.
`ifndef SHARED_EXCLUSIVE_LOCK_QUEUE_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define SELQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define SELQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SELQ_ASSERT(label, prop, msg)
`define SELQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hdl/selq_pkg.sv]
package selq_pkg;

    localparam int CMD_W    = 2;
    localparam int ITEM_W   = 4;
    localparam int CLIENT_W = 4;
    localparam int KIND_W   = 2;

    // Highest client id accepted plus one.
    localparam int NUM_CLIENTS = 16;

    localparam logic [CMD_W-1:0] CMD_SHARED    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXCLUSIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd2;

    localparam logic [KIND_W-1:0] RESP_GRANTED  = 2'd0;
    localparam logic [KIND_W-1:0] RESP_RELEASED = 2'd1;
    localparam logic [KIND_W-1:0] RESP_ERROR    = 2'd2;

    // One waiting request in a lock item's queue.
    typedef struct packed {
        logic                excl;
        logic [CLIENT_W-1:0] client;
    } entry_t;

endpackage

[hdl/selq_req_if.sv]
interface selq_req_if
    import selq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [ITEM_W-1:0]   item_index;
    logic [CLIENT_W-1:0] client_id;

    modport source (
        output valid,
        output command,
        output item_index,
        output client_id,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  item_index,
        input  client_id,
        output ready
    );
endinterface

[hdl/selq_resp_if.sv]
interface selq_resp_if
    import selq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   response_kind;
    logic [CLIENT_W-1:0] target_client;
    logic                last_of_run;

    modport source (
        output valid,
        output response_kind,
        output target_client,
        output last_of_run,
        input  ready
    );

    modport sink (
        input  valid,
        input  response_kind,
        input  target_client,
        input  last_of_run,
        output ready
    );
endinterface

[hdl/selq_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module selq_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/shared_exclusive_lock_queue.sv]
// Channel  Dir  Payload                                     Role
// req      in   command, item_index, client_id              lock / release requests
// resp     out  response_kind, target_client, last_of_run   grants, releases, errors
//
// Steps: an error is answered from the check step; a lock request is appended in the
// check step, then the grant scan spends a RAM read step and a registered-data step
// per entry walked, plus a last step when an all-shared run of two or more reaches
// the tail; a release walks every entry of the item the same way, then a done step.
// The single-port-read queue RAM sets that pace. req.ready is high only between transactions.
// Reset clears the per-item counts at once; queue RAM contents are never read
// before being written. A stalled resp holds the sequencer at its next answer.

`include "shared_exclusive_lock_queue_defines.svh"

module shared_exclusive_lock_queue
    import selq_pkg::*;
#(
    parameter int NUM_ITEMS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input logic        clk,
    input logic        rst_n,
    selq_req_if.sink   req,
    selq_resp_if.source resp
);

    localparam int IW     = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int SW     = $clog2(QUEUE_DEPTH);           // slot index
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);       // count, holds QUEUE_DEPTH
    localparam int DEPTH  = NUM_ITEMS * QUEUE_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_G_RD,
        ST_G_DATA,
        ST_G_LAST,
        ST_R_RD,
        ST_R_DATA,
        ST_R_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ITEM_W-1:0]   item_reg, item_next;
    logic [CLIENT_W-1:0] client_reg, client_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       kept_reg, kept_next;
    logic [CLIENT_W-1:0] pend_reg, pend_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [CLIENT_W-1:0] out_client_reg, out_client_next;
    logic                out_last_reg, out_last_next;

    // Per-item fill counts.
    logic [CW-1:0] count_reg [NUM_ITEMS];
    logic          cnt_wr_en;
    logic [CW-1:0] cnt_wr_data;

    logic [IW-1:0] item_idx;
    logic [CW-1:0] n_cur;
    logic          bad_req;
    logic          out_free;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    entry_t            ram_rd_data;

    selq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign item_idx = IW'(item_reg);
    assign n_cur    = count_reg[item_idx];
    assign out_free = !out_valid_reg || resp.ready;

    // Malformed request: unknown command, item or client out of range.
    assign bad_req = (cmd_reg > CMD_RELEASE)
                  || (32'(item_reg) >= 32'(NUM_ITEMS))
                  || (32'(client_reg) >= 32'(NUM_CLIENTS));

    assign req.ready          = (state_reg == ST_IDLE);
    assign resp.valid         = out_valid_reg;
    assign resp.response_kind = out_kind_reg;
    assign resp.target_client = out_client_reg;
    assign resp.last_of_run   = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        item_next       = item_reg;
        client_next     = client_reg;
        base_next       = base_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        kept_next       = kept_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !resp.ready;
        out_kind_next   = out_kind_reg;
        out_client_next = out_client_reg;
        out_last_next   = out_last_reg;
        cnt_wr_en       = 1'b0;
        cnt_wr_data     = n_cur;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = base_reg + ADDR_W'(n_cur[SW-1:0]);
        ram_wr_data     = '{excl: (cmd_reg == CMD_EXCLUSIVE), client: client_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = base_reg + ADDR_W'(i_reg[SW-1:0]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next    = req.command;
                    item_next   = req.item_index;
                    client_next = req.client_id;
                    base_next   = ADDR_W'(req.item_index) * ADDR_W'(QUEUE_DEPTH);
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (bad_req
                    || (cmd_reg == CMD_RELEASE && n_cur == '0)
                    || (cmd_reg != CMD_RELEASE && n_cur >= CW'(QUEUE_DEPTH)))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = RESP_ERROR;
                        out_client_next = client_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (cmd_reg == CMD_RELEASE)
                begin
                    n_next     = n_cur;
                    i_next     = '0;
                    kept_next  = '0;
                    state_next = ST_R_RD;
                end
                else
                begin
                    // Append at the tail, then rescan from the head.
                    ram_wr_en   = 1'b1;
                    cnt_wr_en   = 1'b1;
                    cnt_wr_data = n_cur + CW'(1);
                    n_next      = n_cur + CW'(1);
                    i_next      = '0;
                    state_next  = ST_G_RD;
                end
            end

            ST_G_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_G_DATA;
            end

            ST_G_DATA:
            begin
                // Grant i-1 is held back until entry i shows whether it ends the run.
                if (out_free)
                begin
                    if (i_reg == '0)
                    begin
                        pend_next = ram_rd_data.client;
                        if (ram_rd_data.excl || n_reg == CW'(1))
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = RESP_GRANTED;
                            out_client_next = ram_rd_data.client;
                            out_last_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = CW'(1);
                            state_next = ST_G_RD;
                        end
                    end
                    else if (ram_rd_data.excl)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = RESP_GRANTED;
                        out_client_next = pend_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = RESP_GRANTED;
                        out_client_next = pend_reg;
                        out_last_next   = 1'b0;
                        pend_next       = ram_rd_data.client;
                        i_next          = i_reg + CW'(1);
                        state_next      = (i_reg + CW'(1) == n_reg) ? ST_G_LAST : ST_G_RD;
                    end
                end
            end

            ST_G_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RESP_GRANTED;
                    out_client_next = pend_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_R_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_R_DATA;
            end

            ST_R_DATA:
            begin
                // Compact in place: kept never passes the read slot.
                ram_wr_addr = base_reg + ADDR_W'(kept_reg[SW-1:0]);
                ram_wr_data = ram_rd_data;
                if (ram_rd_data.client != client_reg)
                begin
                    ram_wr_en = 1'b1;
                    kept_next = kept_reg + CW'(1);
                end
                i_next     = i_reg + CW'(1);
                state_next = (i_reg + CW'(1) == n_reg) ? ST_R_DONE : ST_R_RD;
            end

            ST_R_DONE:
            begin
                if (out_free)
                begin
                    cnt_wr_en       = 1'b1;
                    cnt_wr_data     = kept_reg;
                    out_valid_next  = 1'b1;
                    out_kind_next   = RESP_RELEASED;
                    out_client_next = client_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        item_reg       <= item_next;
        client_reg     <= client_next;
        base_reg       <= base_next;
        n_reg          <= n_next;
        i_reg          <= i_next;
        kept_reg       <= kept_next;
        pend_reg       <= pend_next;
        out_kind_reg   <= out_kind_next;
        out_client_reg <= out_client_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ITEMS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else if (cnt_wr_en)
        begin
            count_reg[item_idx] <= cnt_wr_data;
        end
    end

    // A transaction on req always moves the sequencer into the check step.
    `SELQ_ASSERT(a_accept_to_check, (req.valid && req.ready) |=> (state_reg == ST_CHECK), "accepted request did not reach check")
    // Fill counts stay within the queue depth.
    `SELQ_ASSERT(a_count_bound, (state_reg == ST_CHECK) |-> (n_cur <= CW'(QUEUE_DEPTH)), "fill count above queue depth")
    // The grant scan only reads the queue.
    `SELQ_ASSERT_ALWAYS(a_scan_no_write, (state_reg == ST_G_RD || state_reg == ST_G_DATA || state_reg == ST_G_LAST) |-> !ram_wr_en, "queue written during grant scan")
    // Compaction write slot never overtakes the read slot.
    `SELQ_ASSERT(a_kept_behind, (state_reg == ST_R_DATA) |-> (kept_reg <= i_reg && i_reg < n_reg), "release compaction out of order")

endmodule

[tb/sv/lock_grant_checker.sv]
`timescale 1ns / 1ps

module lock_grant_checker
    import selq_pkg::*;
#(
    parameter int NUM_ITEMS   = 16,
    parameter int QUEUE_DEPTH = 8
) (
    input  logic clk,
    input  logic rst_n,
    selq_req_if  req,
    selq_resp_if resp,
    input  logic end_of_test,
    output int   fail_count,
    output int   pending,
    output int   answers_seen
);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CLIENT_W-1:0] client;
        logic                last;
    } answer_t;

    // Shadow copy of every lock item's wait queue.
    entry_t  lock_fifo [NUM_ITEMS][QUEUE_DEPTH];
    int      fifo_fill [NUM_ITEMS];
    answer_t owed_answers [$];
    int      errors = 0;
    int      seen = 0;
    bit      leftovers_checked = 1'b0;

    function automatic answer_t make_answer(input logic [KIND_W-1:0] kind,
                                            input logic [CLIENT_W-1:0] client,
                                            input logic last);
        answer_t a;
        a.kind   = kind;
        a.client = client;
        a.last   = last;
        return a;
    endfunction

    // Updates the shadow queues for one request and queues the answers it owes.
    task automatic apply_lock_request(input logic [CMD_W-1:0] cmd,
                                      input logic [ITEM_W-1:0] item,
                                      input logic [CLIENT_W-1:0] client);
        answer_t run [$];
        int      n;
        int      kept;
        int      idx;
        idx = int'(item);
        if (!(cmd inside {CMD_SHARED, CMD_EXCLUSIVE, CMD_RELEASE}) ||
            idx >= NUM_ITEMS || int'(client) >= NUM_CLIENTS) begin
            owed_answers = {owed_answers, make_answer(RESP_ERROR, client, 1'b1)};
            return;
        end
        n = fifo_fill[idx];
        if (cmd == CMD_RELEASE) begin
            if (n == 0) begin
                owed_answers = {owed_answers, make_answer(RESP_ERROR, client, 1'b1)};
                return;
            end
            // Compact in place, order of survivors kept.
            kept = 0;
            for (int i = 0; i < n; i++) begin
                if (lock_fifo[idx][i].client != client) begin
                    lock_fifo[idx][kept] = lock_fifo[idx][i];
                    kept++;
                end
            end
            fifo_fill[idx] = kept;
            owed_answers = {owed_answers, make_answer(RESP_RELEASED, client, 1'b1)};
            return;
        end
        if (n >= QUEUE_DEPTH) begin
            owed_answers = {owed_answers, make_answer(RESP_ERROR, client, 1'b1)};
            return;
        end
        lock_fifo[idx][n].client = client;
        lock_fifo[idx][n].excl   = (cmd == CMD_EXCLUSIVE);
        n++;
        fifo_fill[idx] = n;
        // Front is granted; a shared front extends the run to the first writer.
        run = {run, make_answer(RESP_GRANTED, lock_fifo[idx][0].client, 1'b0)};
        if (!lock_fifo[idx][0].excl) begin
            for (int i = 1; i < n; i++) begin
                if (lock_fifo[idx][i].excl)
                    break;
                run = {run, make_answer(RESP_GRANTED, lock_fifo[idx][i].client, 1'b0)};
            end
        end
        run[run.size()-1].last = 1'b1;
        owed_answers = {owed_answers, run};
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        answer_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_ITEMS; i++)
                fifo_fill[i] = 0;
            owed_answers.delete();
            pending <= 0;
        end
        else begin
            if (req.valid && req.ready)
                apply_lock_request(req.command, req.item_index, req.client_id);
            if (resp.valid && resp.ready) begin
                seen++;
                if (owed_answers.size() == 0) begin
                    $error("unexpected response: kind %0d client %0d last %0d",
                           resp.response_kind, resp.target_client, resp.last_of_run);
                    errors++;
                end
                else begin
                    want = owed_answers.pop_front();
                    if (resp.response_kind !== want.kind) begin
                        $error("response_kind: expected %0d, got %0d",
                               want.kind, resp.response_kind);
                        errors++;
                    end
                    if (resp.target_client !== want.client) begin
                        $error("target_client: expected %0d, got %0d",
                               want.client, resp.target_client);
                        errors++;
                    end
                    if (resp.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last, resp.last_of_run);
                        errors++;
                    end
                end
            end
            if (end_of_test && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (owed_answers.size() != 0) begin
                    $error("%0d responses never arrived", owed_answers.size());
                    errors++;
                end
            end
            pending <= owed_answers.size();
        end
    end

    always @(posedge clk) begin
        fail_count   <= errors;
        answers_seen <= seen;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import selq_pkg::*;

    localparam int NUM_ITEMS    = 16;
    localparam int QUEUE_DEPTH  = 8;
    localparam int RANDOM_ITEMS = 84;
    localparam int PHASES       = 4;
    // Worst release walks a full queue; pad generously.
    localparam int DRAIN_CYCLES = 60;
    // ~100 requests, each up to 8 grants, under heavy stall plus sender gaps:
    // allow far more.
    localparam int CYCLE_LIMIT  = 300000;

    // No package name for the unused opcode; the block must answer it with an error.
    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic end_of_test = 1'b0;

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int idle_pct = 0;
    int stall_pct = 0;
    int idle_plan  [PHASES] = '{0, 58, 0, 13};
    int stall_plan [PHASES] = '{0, 0, 58, 13};

    int sent = 0;
    int cycles = 0;
    int fail_count;
    int pending;
    int answers_seen;

    selq_req_if  req_ch ();
    selq_resp_if resp_ch ();

    shared_exclusive_lock_queue #(
        .NUM_ITEMS   (NUM_ITEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    // Watches both channels, predicts every answer and counts mismatches.
    lock_grant_checker #(
        .NUM_ITEMS   (NUM_ITEMS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .resp         (resp_ch),
        .end_of_test  (end_of_test),
        .fail_count   (fail_count),
        .pending      (pending),
        .answers_seen (answers_seen)
    );

    always #5 clk = ~clk;

    // Receiver backpressure: ready drops at random per the current phase.
    always @(posedge clk)
        resp_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one transaction and holds it until the block takes it.
    // valid is only lowered when a gap is actually inserted, so a back-to-back
    // transaction never sees valid dropped and raised in the same step.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ITEM_W-1:0] item,
                                input logic [CLIENT_W-1:0] client);
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.item_index <= item;
        req_ch.client_id  <= client;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // Sender holds off until every owed answer has come back.
    // The checker's count is registered, hence the leading wait.
    task automatic wait_until_quiet();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random traffic kept on a few hot items and a small client pool so queues
    // fill up, hit the full case and get released by real holders.
    task automatic send_random_request();
        int                  r;
        logic [CMD_W-1:0]    cmd;
        logic [ITEM_W-1:0]   item;
        logic [CLIENT_W-1:0] client;
        r = $urandom_range(99);
        if (r < 45)
            cmd = CMD_SHARED;
        else if (r < 75)
            cmd = CMD_EXCLUSIVE;
        else if (r < 97)
            cmd = CMD_RELEASE;
        else
            cmd = CMD_UNDEFINED;
        if ($urandom_range(3) != 0)
            item = ITEM_W'($urandom_range(3));
        else
            item = ITEM_W'($urandom_range(NUM_ITEMS - 1));
        if ($urandom_range(9) < 6)
            client = CLIENT_W'($urandom_range(5));
        else
            client = CLIENT_W'($urandom_range(NUM_CLIENTS - 1));
        send_request(cmd, item, client);
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_SHARED;
        req_ch.item_index = '0;
        req_ch.client_id  = '0;
        resp_ch.ready     = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases, no idling.
        // Release on an empty queue and the unused opcode both answer with an error.
        send_request(CMD_RELEASE, 4'd0, 4'd0);
        send_request(CMD_UNDEFINED, 4'd15, 4'd15);
        // Readers stack up; an exclusive entry ends the grant run.
        send_request(CMD_SHARED, 4'd0, 4'd1);
        send_request(CMD_SHARED, 4'd0, 4'd2);
        send_request(CMD_EXCLUSIVE, 4'd0, 4'd3);
        send_request(CMD_SHARED, 4'd0, 4'd4);
        // Fill item 0 to its depth, then one more is dropped as full.
        for (int c = 5; c <= 8; c++)
            send_request(CMD_SHARED, 4'd0, CLIENT_W'(c));
        send_request(CMD_SHARED, 4'd0, 4'd9);
        // Drop the writer: refilling with a reader yields a full-depth grant run.
        send_request(CMD_RELEASE, 4'd0, 4'd3);
        send_request(CMD_SHARED, 4'd0, 4'd1);
        // Client with two entries loses both; a non-holder still gets released.
        send_request(CMD_RELEASE, 4'd0, 4'd1);
        send_request(CMD_RELEASE, 4'd0, 4'd0);
        // Exclusive at the front blocks the readers behind it.
        send_request(CMD_EXCLUSIVE, 4'd15, 4'd15);
        send_request(CMD_SHARED, 4'd15, 4'd0);
        send_request(CMD_RELEASE, 4'd15, 4'd15);
        send_request(CMD_SHARED, 4'd15, 4'd14);
        wait_until_quiet();

        // Random phases: none, sender idle, receiver stall, both.
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_pct  = idle_plan[phase];
            stall_pct = stall_plan[phase];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                send_random_request();
                if ($urandom_range(19) == 0)
                    wait_until_quiet();
            end
            wait_until_quiet();
        end

        // Let any trailing work finish, then have the checker flag leftovers.
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Covered %0d lock/release transactions and %0d responses: corner cases,",
                 sent, answers_seen);
        $display("then random traffic under sender idling and response backpressure.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/selq_pkg.sv
hdl/selq_req_if.sv
hdl/selq_resp_if.sv
hdl/selq_ram.sv
hdl/shared_exclusive_lock_queue.sv
tb/sv/lock_grant_checker.sv
tb/sv/testbench.sv
